[rtl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the slice shuffle descrambler
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int FILE_W      = 25;
  localparam int OFF_W       = 24;
  localparam int SLICE_SHIFT = 5;
  localparam int SLICE_BYTES = 32;
  localparam int DEF_MAX_CHUNK_BYTES = 2097152;

  // generator constants
  localparam int SEED_W = 15;
  localparam int RAND_W = 16;
  localparam logic [11:0]       LCG_MUL = 12'd2109;
  localparam logic [13:0]       LCG_ADD = 14'd9273;
  localparam logic [RAND_W-1:0] LCG_OFS = 16'hc000;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_SIZE,
    ST_FILL,
    ST_RAND,
    ST_MUL,
    ST_RD_I,
    ST_RD_X,
    ST_WR_I,
    ST_WR_X
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic set_tail;
    logic chunk_init;
    logic shrink;
    logic fill_start;
    logic fill_step;
    logic fill_end;
    logic rand_step;
    logic mul_step;
    logic rd_i;
    logic rd_x;
    logic wr_i;
    logic wr_x;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_setup;
    logic chunk_open;
    logic tail_cond;
    logic shrink_cond;
    logic fill_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/sss_ctrl.sv]
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer: chunk sizing, table refill, per-slice shuffle and beat flow
// ----------------------------------------------------------------------------
module sss_ctrl import sss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_RUN: begin
        if (stat.need_setup) begin
          if (stat.chunk_open) begin
            state_next = ST_RAND;
          end else if (stat.tail_cond) begin
            cmd.set_tail = 1'b1;
          end else begin
            cmd.chunk_init = 1'b1;
            state_next     = ST_SIZE;
          end
        end else begin
          in_ready   = stat.out_free;
          cmd.accept = in_valid && stat.out_free;
        end
      end
      ST_SIZE: begin
        if (stat.shrink_cond) begin
          cmd.shrink = 1'b1;
        end else begin
          cmd.fill_start = 1'b1;
          state_next     = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.fill_end = 1'b1;
          state_next   = ST_RAND;
        end
      end
      ST_RAND: begin
        cmd.rand_step = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = ST_RD_I;
      end
      ST_RD_I: begin
        cmd.rd_i   = 1'b1;
        state_next = ST_RD_X;
      end
      ST_RD_X: begin
        cmd.rd_x   = 1'b1;
        state_next = ST_WR_I;
      end
      ST_WR_I: begin
        cmd.wr_i   = 1'b1;
        state_next = ST_WR_X;
      end
      ST_WR_X: begin
        cmd.wr_x   = 1'b1;
        state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

endmodule

[rtl/sss_dpath.sv]
// ----------------------------------------------------------------------------
// sss_dpath
// Walk registers, generator, slice table memory and output register
// ----------------------------------------------------------------------------
module sss_dpath import sss_pkg::*; #(
  parameter int MAX_CHUNK_BYTES = DEF_MAX_CHUNK_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [FILE_W-1:0] cfg_wdata,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OFF_W-1:0]  dest_offset,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              excess
);

  localparam int DEPTH = MAX_CHUNK_BYTES / SLICE_BYTES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB_W  = $clog2(MAX_CHUNK_BYTES) + 1;
  localparam int N_W   = CB_W - SLICE_SHIFT;
  localparam logic [CB_W-1:0] MAX_CB = CB_W'(MAX_CHUNK_BYTES);
  localparam logic [CB_W-1:0] MIN_CB = CB_W'(SLICE_BYTES);

  logic [FILE_W-1:0] size_total, bytes_left, bytes_seen;
  logic [CB_W-1:0]   chunk_bytes;
  logic [OFF_W-1:0]  chunk_base, slice_target;
  logic [IDX_W-1:0]  slice_number, fill_k, x_idx, t_i;
  logic [4:0]        byte_in_slice;
  logic              tail_mode, chunk_open;
  logic              slice_live;
  logic [SEED_W-1:0] lcg_seed;

  // slice table
  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rdata, waddr, wdata, raddr;
  logic             mem_we;

  logic [N_W-1:0]          n_slices;
  logic [IDX_W-1:0]        n_last;
  logic [26:0]             seed_prod;
  logic [RAND_W-1:0]       rnd;
  logic [RAND_W+IDX_W-1:0] x_prod;
  logic                    is_excess;
  logic [FILE_W:0]         seen_inc;

  assign n_slices  = N_W'(chunk_bytes >> SLICE_SHIFT);
  assign n_last    = IDX_W'(n_slices - N_W'(1));
  assign seed_prod = 27'(lcg_seed) * 27'(LCG_MUL) + 27'(LCG_ADD);
  assign rnd       = RAND_W'(lcg_seed) + LCG_OFS;
  assign x_prod    = (RAND_W+IDX_W)'(rnd) * (RAND_W+IDX_W)'(slice_number);
  assign is_excess = bytes_seen >= size_total;
  assign seen_inc  = {1'b0, bytes_seen} + (FILE_W+1)'(1);

  // status to controller
  always_comb begin
    stat.need_setup  = (byte_in_slice == 5'd0) && !slice_live && !tail_mode && !is_excess;
    stat.chunk_open  = chunk_open;
    stat.tail_cond   = bytes_left < FILE_W'(SLICE_BYTES);
    stat.shrink_cond = (FILE_W'(chunk_bytes) > bytes_left) && (chunk_bytes > MIN_CB);
    stat.fill_last   = fill_k == n_last;
    stat.out_free    = !out_valid || out_ready;
  end

  // table port selection
  always_comb begin
    mem_we = cmd.fill_step || cmd.wr_i || cmd.wr_x;
    raddr  = cmd.rd_i ? slice_number : x_idx;
    waddr  = fill_k;
    wdata  = fill_k;
    if (cmd.wr_i) begin
      waddr = slice_number;
      wdata = rdata;
    end else if (cmd.wr_x) begin
      waddr = x_idx;
      wdata = t_i;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // walk state and generator
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      size_total    <= rst ? '0 : cfg_wdata;
      bytes_left    <= rst ? '0 : cfg_wdata;
      lcg_seed      <= rst ? '0 : cfg_wdata[SEED_W-1:0];
      bytes_seen    <= '0;
      chunk_bytes   <= MAX_CB;
      chunk_base    <= '0;
      slice_target  <= '0;
      slice_number  <= '0;
      byte_in_slice <= '0;
      tail_mode     <= 1'b0;
      chunk_open    <= 1'b0;
      slice_live    <= 1'b0;
      fill_k        <= '0;
    end else begin
      if (cmd.set_tail) begin
        tail_mode    <= 1'b1;
        slice_target <= chunk_base;
      end
      if (cmd.chunk_init) chunk_bytes <= MAX_CB;
      if (cmd.shrink)     chunk_bytes <= chunk_bytes >> 1;
      if (cmd.fill_start) fill_k <= '0;
      if (cmd.fill_step)  fill_k <= fill_k + IDX_W'(1);
      if (cmd.fill_end) begin
        slice_number <= n_last;
        chunk_open   <= 1'b1;
      end
      if (cmd.rand_step) lcg_seed <= seed_prod[SEED_W-1:0];
      if (cmd.mul_step)  x_idx <= IDX_W'(x_prod >> RAND_W);
      if (cmd.rd_x)      t_i <= rdata;
      if (cmd.wr_i) begin
        slice_target <= chunk_base + (OFF_W'(rdata) << SLICE_SHIFT);
      end
      // slice placed, bytes may flow
      if (cmd.wr_x) slice_live <= 1'b1;
      // one beat of the walk
      if (cmd.accept && !is_excess) begin
        byte_in_slice <= byte_in_slice + 5'd1;
        bytes_seen    <= seen_inc[FILE_W-1:0];
        if (byte_in_slice == 5'd31 && !tail_mode) begin
          slice_live <= 1'b0;
          if (slice_number == '0) begin
            chunk_open <= 1'b0;
            chunk_base <= chunk_base + OFF_W'(chunk_bytes);
            bytes_left <= bytes_left - FILE_W'(chunk_bytes);
          end else begin
            slice_number <= slice_number - IDX_W'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      out_valid <= 1'b0;
    end else if (cmd.accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_byte <= data_byte;
      excess   <= is_excess;
      if (is_excess) begin
        dest_offset <= '0;
        last        <= 1'b0;
      end else begin
        dest_offset <= slice_target + OFF_W'(byte_in_slice);
        last        <= seen_inc == {1'b0, size_total};
      end
    end
  end

endmodule

[rtl/slice_shuffle_descrambler.sv]
// ----------------------------------------------------------------------------
// slice_shuffle_descrambler
// Gives each byte of a slice-shuffled file with its destination offset
// ----------------------------------------------------------------------------
// Usage:
//   write the file size on cfg_we/cfg_wdata while idle; this restarts the
//   walk and seeds the generator. Bytes then enter on in_valid/in_ready, one
//   beat per byte, and leave on out_valid/out_ready with dest_offset, last
//   and excess. Every input beat gives exactly one output beat.
// Output: out_valid rises in the cycle after a beat is accepted.
// Throughput: one beat per cycle inside a 32-byte slice while the output
//   is not stalled. Each slice start runs a decision step, generator step,
//   multiply, two table reads and two writes on the slice table, which has
//   one read and one write port. Each chunk start adds a size search that
//   halves the chunk while it exceeds the bytes left, down to one slice, and
//   an identity refill of the table, one slice per step. Without a stall,
//   tail bytes run at one per cycle once the tail is entered, excess bytes likewise.
// Reset: walk counters cleared, chunk size at its maximum, file size zero, so every byte is excess.
// Stall: a held out_ready keeps the output register; input is taken only
//   when the register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module slice_shuffle_descrambler import sss_pkg::*; #(
  parameter int MAX_CHUNK_BYTES = DEF_MAX_CHUNK_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [FILE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OFF_W-1:0]  dest_offset,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              excess
);

  cmd_t  cmd;
  stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_dpath #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dest_offset (dest_offset),
    .out_byte    (out_byte),
    .last        (last),
    .excess      (excess)
  );

  // an accepted beat always shows up at the output
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_we) |=> out_valid)
    else $error("accepted beat not presented");

  // a restart empties the output register
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !out_valid)
    else $error("output kept over restart");

  // excess beats carry no offset and never end the file
  a_excess: assert property (@(posedge clk) disable iff (rst)
    (out_valid && excess) |-> (dest_offset == '0 && !last))
    else $error("excess beat with offset or last");

endmodule
